>>> src/bwr_pkg.sv
// Shared types and constants for the bandwidth watermark router timing block.
// No dependencies; used by the channel interfaces, the top level and the
// checker.
`default_nettype none

package bwr_pkg;

  localparam int unsigned WmWidth = 48;
  localparam int unsigned LatWidth = 32;
  localparam int unsigned ApbAddrWidth = 3;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes (paddr[2])
  localparam logic REG_BANDWIDTH = 1'b0;
  localparam logic REG_ROUTER_LAT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  in_port;
    logic [3:0]  out_port;
    logic        decode_ok;
    logic [31:0] addr;
    logic [31:0] base_sub;
    logic [31:0] base_add;
    logic [7:0]  map_latency;
    logic [15:0] size;
    logic [47:0] now;
    logic [1:0]  target_status;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        queued;
    logic        forwarded;
    logic [31:0] latency;
    logic [31:0] out_addr;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MAX,
    S_DIV,
    S_SUM1,
    S_SUM2,
    S_RESP
  } state_e;

endpackage

`default_nettype wire

>>> src/bwr_req_if.sv
// Request channel: valid/ready handshake carrying one request or retry item.
// Depends on bwr_pkg.
`default_nettype none

interface bwr_req_if;
  logic          valid;
  logic          ready;
  bwr_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/bwr_rsp_if.sv
// Response channel: valid/ready handshake carrying one annotated result.
// Depends on bwr_pkg.
`default_nettype none

interface bwr_rsp_if;
  logic          valid;
  logic          ready;
  bwr_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/bwr_ceil_div.sv
// Radix-2 restoring divider giving ceil(dividend / divisor) for 16-bit values.
// One quotient bit per cycle. No package dependency.
`default_nettype none

module bwr_ceil_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [15:0]      quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;
  logic [15:0] rem_q, rem_d;
  logic [15:0] sq_q, sq_d;   // dividend shifts out, quotient shifts in
  logic [15:0] dvs_q;
  logic [16:0] trial;
  logic [17:0] diff;
  logic        fits;

  always_comb begin
    trial = {rem_q, sq_q[15]};
    diff  = {1'b0, trial} - {2'b00, dvs_q};
    fits  = ~diff[17];
    rem_d = fits ? diff[15:0] : trial[15:0];
    sq_d  = {sq_q[14:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd15;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      sq_q  <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sq_q  <= sq_d;
    end
  end

  // round up when anything is left over
  assign quot_o = sq_q + {15'd0, (rem_q != '0)};
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> src/bandwidth_watermark_router_timing.sv
// Top level of the bandwidth watermark router timing block.
// Depends on bwr_pkg, bwr_req_if, bwr_rsp_if and bwr_ceil_div.
//
// One item is handled at a time. A retry, a bad decode, a stalled output or a
// denial goes from the decide state straight to the result state, with its
// result register written in decide. A forwarded request passes through the
// max, div, sum1 and sum2 states before the result state; the div state is
// entered only when bandwidth is nonzero and waits for the bit-serial divider
// that computes ceil(size / bandwidth), one quotient bit per cycle, and its done flag.
// The request channel is not ready from a transfer until its result has been
// taken and is ready again the cycle after. Watermarks and stall flags are
// cleared by reset; bandwidth and the router latency register reset to zero and
// are written through the APB port; the user must write them only while the
// block is idle, which the block itself does not enforce.
`default_nettype none

module bandwidth_watermark_router_timing #(
  parameter int unsigned NUM_INPUTS  = 8,
  parameter int unsigned NUM_OUTPUTS = 16,
  parameter int unsigned ADDR_WIDTH  = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  bwr_req_if.sink                                req_i,
  bwr_rsp_if.source                              rsp_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bwr_pkg::ApbAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int unsigned InIdxW  = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int unsigned OutIdxW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam logic [31:0] AddrMask =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam int unsigned WmW = bwr_pkg::WmWidth;

  // configuration
  logic [15:0] bw_q;
  logic [15:0] rlat_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == bwr_pkg::REG_ROUTER_LAT) ? {16'd0, rlat_q} : {16'd0, bw_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q   <= '0;
      rlat_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        bwr_pkg::REG_BANDWIDTH:  bw_q   <= pwdata[15:0];
        bwr_pkg::REG_ROUTER_LAT: rlat_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // state
  bwr_pkg::state_e state_q, state_d;
  bwr_pkg::req_t   item_q;
  bwr_pkg::rsp_t   res_q;
  logic [WmW-1:0]  iwm_q [NUM_INPUTS];
  logic [WmW-1:0]  owm_q [NUM_OUTPUTS];
  logic [NUM_OUTPUTS-1:0] stall_q;
  logic [WmW-1:0]  start_q;
  logic [WmW-1:0]  wait_q;
  logic [15:0]     burst_q;
  logic [17:0]     fixed_q;

  // port decode
  logic [6:0]         ip_ext, op_ext;
  logic [InIdxW-1:0]  ip_idx;
  logic [OutIdxW-1:0] op_idx;
  logic               ip_ok, op_ok;

  always_comb begin
    ip_ext = {4'd0, item_q.in_port};
    op_ext = {3'd0, item_q.out_port};
    ip_idx = ip_ext[InIdxW-1:0];
    op_idx = op_ext[OutIdxW-1:0];
    ip_ok  = ip_ext < 7'(NUM_INPUTS);
    op_ok  = op_ext < 7'(NUM_OUTPUTS);
  end

  // divider
  logic        div_start;
  logic        div_done;
  logic [15:0] div_quot;

  assign div_start = (state_q == bwr_pkg::S_MAX) && (bw_q != '0);

  bwr_ceil_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (item_q.size),
    .divisor_i  (bw_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // decision in S_DECIDE
  logic        is_retry, is_bad, is_stalled, is_denied;
  logic [31:0] xlat_addr;

  always_comb begin
    is_retry   = item_q.req_type;
    is_bad     = !item_q.decode_ok || !ip_ok || !op_ok;
    is_stalled = stall_q[op_idx];
    is_denied  = item_q.target_status[1];
    xlat_addr  = (item_q.addr - item_q.base_sub + item_q.base_add) & AddrMask;
  end

  // arithmetic of the forwarding path
  logic [WmW:0]   iwm_sum;
  logic [WmW-1:0] iwm_new;
  logic [WmW+1:0] lat_sum, owm_sum;
  logic [31:0]    lat_sat;
  logic [WmW-1:0] owm_new;

  always_comb begin
    iwm_sum = {1'b0, start_q} + {33'd0, burst_q};
    iwm_new = iwm_sum[WmW] ? '1 : iwm_sum[WmW-1:0];
    lat_sum = {2'b00, wait_q} + {32'd0, fixed_q};
    lat_sat = (lat_sum[WmW+1:32] != '0) ? '1 : lat_sum[31:0];
    owm_sum = {2'b00, start_q} + {32'd0, fixed_q};
    owm_new = (owm_sum[WmW+1:WmW] != '0) ? '1 : owm_sum[WmW-1:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bwr_pkg::S_IDLE:   if (req_i.valid) state_d = bwr_pkg::S_DECIDE;
      bwr_pkg::S_DECIDE: begin
        if (is_retry || is_bad || is_stalled || is_denied) begin
          state_d = bwr_pkg::S_RESP;
        end else begin
          state_d = bwr_pkg::S_MAX;
        end
      end
      bwr_pkg::S_MAX:    state_d = (bw_q != '0) ? bwr_pkg::S_DIV : bwr_pkg::S_SUM1;
      bwr_pkg::S_DIV:    if (div_done) state_d = bwr_pkg::S_SUM1;
      bwr_pkg::S_SUM1:   state_d = bwr_pkg::S_SUM2;
      bwr_pkg::S_SUM2:   state_d = bwr_pkg::S_RESP;
      bwr_pkg::S_RESP:   if (rsp_o.ready) state_d = bwr_pkg::S_IDLE;
      default:           state_d = bwr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bwr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_i.ready   = (state_q == bwr_pkg::S_IDLE);
  assign rsp_o.valid   = (state_q == bwr_pkg::S_RESP);
  assign rsp_o.payload = res_q;

  // watermarks and stall flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_q <= '0;
      for (int i = 0; i < NUM_INPUTS; i++) iwm_q[i] <= '0;
      for (int i = 0; i < NUM_OUTPUTS; i++) owm_q[i] <= '0;
    end else begin
      if (state_q == bwr_pkg::S_DECIDE) begin
        if (is_retry) begin
          if (op_ok) stall_q[op_idx] <= 1'b0;
        end else if (!is_bad && !is_stalled && is_denied) begin
          stall_q[op_idx] <= 1'b1;
        end
      end
      if (state_q == bwr_pkg::S_SUM1) iwm_q[ip_idx] <= iwm_new;
      if (state_q == bwr_pkg::S_SUM2) owm_q[op_idx] <= owm_new;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bwr_pkg::S_IDLE: begin
        if (req_i.valid) item_q <= req_i.payload;
      end
      bwr_pkg::S_DECIDE: begin
        res_q.latency <= '0;
        if (is_retry) begin
          res_q.status    <= bwr_pkg::ST_DONE;
          res_q.queued    <= 1'b0;
          res_q.forwarded <= 1'b0;
          res_q.out_addr  <= '0;
        end else if (is_bad) begin
          res_q.status    <= bwr_pkg::ST_INVALID;
          res_q.queued    <= 1'b0;
          res_q.forwarded <= 1'b0;
          res_q.out_addr  <= item_q.addr;
        end else if (is_stalled || is_denied) begin
          res_q.status    <= bwr_pkg::ST_GRANTED;
          res_q.queued    <= 1'b1;
          res_q.forwarded <= 1'b0;
          res_q.out_addr  <= item_q.addr;
        end else begin
          res_q.status    <= item_q.target_status;
          res_q.queued    <= 1'b0;
          res_q.forwarded <= 1'b1;
          res_q.out_addr  <= xlat_addr;
        end
        start_q <= (iwm_q[ip_idx] > item_q.now) ? iwm_q[ip_idx] : item_q.now;
        burst_q <= '0;
      end
      bwr_pkg::S_MAX: begin
        if (owm_q[op_idx] > start_q) start_q <= owm_q[op_idx];
      end
      bwr_pkg::S_DIV: begin
        if (div_done) burst_q <= div_quot;
      end
      bwr_pkg::S_SUM1: begin
        wait_q  <= start_q - item_q.now;
        fixed_q <= {2'b00, rlat_q} + {10'd0, item_q.map_latency} + {2'b00, burst_q};
      end
      bwr_pkg::S_SUM2: begin
        res_q.latency <= lat_sat;
      end
      bwr_pkg::S_RESP: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/bwr_checker.sv
// Port-level checker for the bandwidth watermark router timing block, bound
// to the top level. Depends on bwr_pkg.
`default_nettype none

module bwr_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_ready_i,
  input wire logic          rsp_valid_i,
  input wire logic          rsp_ready_i,
  input wire bwr_pkg::rsp_t rsp_payload_i
);

  // no new item while a result is pending
  a_busy_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request channel ready while a result is pending");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !rsp_valid_i)
    else $error("result shown in the cycle after a request transfer");

  // no result shown again straight after a response transfer
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_ready_i) |=> !rsp_valid_i)
    else $error("second result after a response transfer");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_payload_i)))
    else $error("stalled result dropped or changed");

  a_fwd_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_payload_i.forwarded) |->
      (!rsp_payload_i.queued && rsp_payload_i.status != bwr_pkg::ST_INVALID))
    else $error("forwarded result marked queued or invalid");

endmodule

bind bandwidth_watermark_router_timing bwr_checker u_bwr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for bandwidth_watermark_router_timing: directed cases, then random request/retry
// streams under several register settings, checked against a scoreboard that tracks watermarks.
// Depends on bwr_pkg, bwr_req_if, bwr_rsp_if and the block itself.

module tb_top;

  // downstream reply codes carried in target_status
  localparam logic [1:0] TGT_DONE       = 2'd0;
  localparam logic [1:0] TGT_GRANTED    = 2'd1;
  localparam logic [1:0] TGT_DENIED     = 2'd2;
  localparam logic [1:0] TGT_DENIED_ALT = 2'd3;

  localparam int unsigned NumIn  = 8;
  localparam int unsigned NumOut = 16;
  localparam logic [63:0] WmSat  = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] LatSat = 64'hFFFF_FFFF;
  // the limit lies far above a forwarded item, short ready stalls, the settle time and
  // two register writes around a reconfiguration
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 30;
  localparam int unsigned PhaseItems   = 290;
  localparam int unsigned NumPhases    = 5;

  class wm_scoreboard;
    logic [15:0]   bw;
    logic [15:0]   rtr_lat;
    logic [47:0]   in_wm[NumIn];
    logic [47:0]   out_wm[NumOut];
    bit            stalled[NumOut];
    bwr_pkg::rsp_t expected_rsp[$];
    int unsigned   errors;

    function new();
      bw = '0;
      rtr_lat = '0;
      errors = 0;
      foreach (in_wm[i]) in_wm[i] = '0;
      foreach (out_wm[i]) out_wm[i] = '0;
      foreach (stalled[i]) stalled[i] = 1'b0;
    endfunction

    function void set_reg(input logic idx, input logic [15:0] val);
      if (idx == bwr_pkg::REG_BANDWIDTH) bw = val;
      else rtr_lat = val;
    endfunction

    function int unsigned pending();
      return expected_rsp.size();
    endfunction

    // work out the result of one accepted item and update the watermarks
    function void accept_request(input bwr_pkg::req_t r);
      bwr_pkg::rsp_t e;
      logic [63:0]   t;
      logic [63:0]   hold_in;
      logic [63:0]   hold_out;
      logic [63:0]   hold;
      logic [63:0]   burst;
      logic [63:0]   lat;
      logic [63:0]   start_at;
      logic [63:0]   nxt;
      e = '0;
      t = {16'h0, r.now};
      if (r.req_type) begin
        stalled[r.out_port] = 1'b0;
      end else if (!r.decode_ok) begin
        e.status = bwr_pkg::ST_INVALID;
        e.out_addr = r.addr;
      end else if (stalled[r.out_port]) begin
        e.status = bwr_pkg::ST_GRANTED;
        e.queued = 1'b1;
        e.out_addr = r.addr;
      end else if (r.target_status >= TGT_DENIED) begin
        stalled[r.out_port] = 1'b1;
        e.status = bwr_pkg::ST_GRANTED;
        e.queued = 1'b1;
        e.out_addr = r.addr;
      end else begin
        hold_in = (in_wm[r.in_port] > r.now) ? {16'h0, in_wm[r.in_port]} - t : '0;
        hold_out = (out_wm[r.out_port] > r.now) ? {16'h0, out_wm[r.out_port]} - t : '0;
        hold = (hold_in > hold_out) ? hold_in : hold_out;
        burst = '0;
        if (bw != 0) burst = ({48'h0, r.size} + {48'h0, bw} - 64'd1) / {48'h0, bw};
        lat = hold + {48'h0, rtr_lat} + {56'h0, r.map_latency} + burst;
        start_at = t + hold;
        nxt = start_at + burst;
        in_wm[r.in_port] = (nxt > WmSat) ? WmSat[47:0] : nxt[47:0];
        nxt = t + lat;
        out_wm[r.out_port] = (nxt > WmSat) ? WmSat[47:0] : nxt[47:0];
        e.status = r.target_status;
        e.forwarded = 1'b1;
        e.latency = (lat > LatSat) ? LatSat[31:0] : lat[31:0];
        e.out_addr = r.addr - r.base_sub + r.base_add;
      end
      expected_rsp.insert(expected_rsp.size(), e);
    endfunction

    function void compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(input bwr_pkg::rsp_t got);
      bwr_pkg::rsp_t e;
      if (expected_rsp.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      e = expected_rsp[0];
      expected_rsp.delete(0);
      compare_field("status", e.status, got.status);
      compare_field("queued", e.queued, got.queued);
      compare_field("forwarded", e.forwarded, got.forwarded);
      compare_field("latency", e.latency, got.latency);
      compare_field("out_addr", e.out_addr, got.out_addr);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [bwr_pkg::ApbAddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bwr_req_if req_if ();
  bwr_rsp_if rsp_if ();

  wm_scoreboard sb = new();
  bit           calm = 1'b0;
  logic [47:0]  clk_now = '0;
  int unsigned  quiet_cycles = 0;

  bandwidth_watermark_router_timing dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) sb.accept_request(req_if.payload);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("FAIL bandwidth_watermark_router_timing");
      $finish;
    end
  end

  // called and returning at a falling edge; valid stays high for a following item
  task automatic send_item(input bwr_pkg::req_t r);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 8) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reconfigure(input logic [15:0] bw, input logic [15:0] rtr_lat);
    pause_until_drained();
    repeat (SettleCycles) @(negedge clk_i);
    apb_write(bwr_pkg::REG_BANDWIDTH, bw);
    apb_write(bwr_pkg::REG_ROUTER_LAT, rtr_lat);
  endtask

  function automatic bwr_pkg::req_t noise_item();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(bwr_pkg::req_t)-1:0];
  endfunction

  function automatic bwr_pkg::req_t fwd_item(input logic [2:0] ip, input logic [3:0] op,
                                             input logic [1:0] ts, input logic [15:0] sz,
                                             input logic [47:0] t);
    bwr_pkg::req_t r;
    r = noise_item();
    r.req_type = 1'b0;
    r.decode_ok = 1'b1;
    r.in_port = ip;
    r.out_port = op;
    r.target_status = ts;
    r.size = sz;
    r.now = t;
    return r;
  endfunction

  function automatic bwr_pkg::req_t retry_item(input logic [3:0] op);
    bwr_pkg::req_t r;
    r = noise_item();
    r.req_type = 1'b1;
    r.out_port = op;
    return r;
  endfunction

  // mostly well-formed requests on an advancing clock, with retries, bad decodes and noise
  function automatic bwr_pkg::req_t random_item();
    bwr_pkg::req_t r;
    int unsigned   pick;
    int unsigned   roll;
    logic [1:0]    ts;
    logic [15:0]   sz;
    if ($urandom_range(99) == 0 && clk_now < 48'hE000_0000_0000)
      clk_now += 48'({$urandom, $urandom} >> $urandom_range(20, 40));
    clk_now += 48'($urandom_range(40));
    sz = ($urandom_range(99) < 4) ? 16'($urandom) : 16'($urandom_range(300));
    roll = $urandom_range(99);
    if (roll < 86) ts = 2'($urandom_range(1));
    else if (roll < 95) ts = TGT_DENIED;
    else ts = TGT_DENIED_ALT;
    pick = $urandom_range(99);
    if (pick < 72) begin
      r = fwd_item(3'($urandom_range(NumIn - 1)), 4'($urandom_range(NumOut - 1)), ts, sz,
                   clk_now);
    end else if (pick < 86) begin
      r = retry_item(4'($urandom_range(NumOut - 1)));
    end else if (pick < 94) begin
      r = noise_item();
      r.req_type = 1'b0;
      r.decode_ok = 1'b0;
    end else begin
      r = noise_item();
      // keep forwarded noise on the running clock so watermarks stay meaningful
      if (!r.req_type && r.decode_ok && r.target_status < TGT_DENIED) r.now = clk_now;
    end
    return r;
  endfunction

  initial begin
    bwr_pkg::req_t r;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset register values: no burst time, no router latency
    r = fwd_item(3'd0, 4'd0, TGT_DONE, 16'h0, 48'd0);
    r.addr = '0;
    r.base_sub = '0;
    r.base_add = '0;
    r.map_latency = '0;
    send_item(r);
    r = fwd_item(3'd7, 4'd15, TGT_GRANTED, 16'hFFFF, 48'd5);
    r.addr = '1;
    r.base_sub = '0;
    r.base_add = '1;
    r.map_latency = 8'hFF;
    send_item(r);
    send_item(retry_item(4'd3));
    r = fwd_item(3'd2, 4'd5, TGT_DENIED, 16'd100, 48'd10);
    r.decode_ok = 1'b0;                   // bad decode must not stall the output
    send_item(r);
    send_item(fwd_item(3'd2, 4'd5, TGT_DONE, 16'd100, 48'd10));
    send_item(fwd_item(3'd1, 4'd3, TGT_DENIED, 16'd8, 48'd20));
    send_item(fwd_item(3'd1, 4'd3, TGT_DONE, 16'd8, 48'd21));
    send_item(fwd_item(3'd1, 4'd4, TGT_DENIED_ALT, 16'd8, 48'd22));
    send_item(retry_item(4'd3));
    send_item(fwd_item(3'd1, 4'd3, TGT_GRANTED, 16'd8, 48'd23));
    send_item(retry_item(4'd4));
    send_item(fwd_item(3'd1, 4'd4, TGT_DONE, 16'd8, 48'd24));

    reconfigure(16'd1, 16'hFFFF);
    send_item(fwd_item(3'd6, 4'd9, TGT_DONE, 16'hFFFF, 48'd30));
    send_item(fwd_item(3'd6, 4'd10, TGT_GRANTED, 16'd3, 48'd30));
    send_item(fwd_item(3'd0, 4'd9, TGT_DONE, 16'd3, 48'd31));
    reconfigure(16'hFFFF, 16'd0);
    send_item(fwd_item(3'd2, 4'd2, TGT_DONE, 16'hFFFF, 48'd100000));
    send_item(fwd_item(3'd2, 4'd2, TGT_DONE, 16'd0, 48'd100000));
    send_item(fwd_item(3'd2, 4'd2, TGT_DONE, 16'd1, 48'd100000));

    clk_now = 48'd200000;
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: reconfigure(16'($urandom_range(1, 16)), 16'($urandom_range(50)));
        1: reconfigure(16'd0, 16'hFFFF);
        2: reconfigure(16'hFFFF, 16'($urandom));
        3: reconfigure(16'($urandom), 16'($urandom));
        default: reconfigure(16'd1, 16'd0);
      endcase
      calm = (ph == 2);
      for (int unsigned i = 0; i < PhaseItems; i++) begin
        if (ph == 1 && i == PhaseItems / 2) pause_until_drained();
        send_item(random_item());
      end
      calm = 1'b0;
    end

    // saturation: latency past 32 bits, watermarks pinned at the top of 48 bits
    reconfigure(16'd1, 16'hFFFF);
    send_item(fwd_item(3'd5, 4'd13, TGT_DONE, 16'hFFFF, 48'h100_0000_0000));
    send_item(fwd_item(3'd5, 4'd13, TGT_GRANTED, 16'hFFFF, 48'd0));
    r = fwd_item(3'd4, 4'd12, TGT_DONE, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    r.map_latency = 8'hFF;
    send_item(r);
    send_item(fwd_item(3'd4, 4'd12, TGT_DONE, 16'hFFFF, 48'd0));

    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS bandwidth_watermark_router_timing");
    end else begin
      $display("FAIL bandwidth_watermark_router_timing");
    end
    $finish;
  end

endmodule

>>> bandwidth_watermark_router_timing.f
src/bwr_pkg.sv
src/bwr_req_if.sv
src/bwr_rsp_if.sv
src/bwr_ceil_div.sv
src/bandwidth_watermark_router_timing.sv
src/bwr_checker.sv
test/tb_top.sv
